FILE: rtl/etsw_pkg.sv
// ----------------------------------------------------------------------------
// etsw_pkg
// Shared types and constants of the event time surface window block.
// ----------------------------------------------------------------------------
package etsw_pkg;

    localparam int SENSOR_WIDTH_DEF  = 128;
    localparam int SENSOR_HEIGHT_DEF = 128;
    localparam int RADIUS_X_DEF      = 3;
    localparam int RADIUS_Y_DEF      = 3;

    localparam logic [1:0] MODE_UPDATE  = 2'd0;
    localparam logic [1:0] MODE_COMPUTE = 2'd1;
    localparam logic [1:0] MODE_BOTH    = 2'd2;
    localparam logic [1:0] MODE_WEIGHT  = 2'd3;

    localparam logic [1:0] REG_DECAY  = 2'd0;
    localparam logic [1:0] REG_MINACT = 2'd1;
    localparam logic [1:0] REG_USEW   = 2'd2;

    localparam logic [31:0] DECAY_RESET  = 32'd1000;
    localparam logic [5:0]  MINACT_RESET = 6'd6;

    localparam int VAL_W   = 17;
    localparam int QUOT_W  = 16;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture the accepted item
        logic mem_write;  // write time or weight store at the item pixel
        logic clr_step;   // one step of the post-reset mark clearing sweep
        logic rd_cell;    // issue reads for the current window cell
        logic div_start;  // start the divider on the read data
        logic div_step;   // one divider iteration
        logic mul;        // weighting multiply
        logic out_load;   // load the output register
        logic next_cell;  // advance the window counters
        logic out_take;   // output transfer completed
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic win_end;
        logic out_full;
        logic is_compute;
    } t_sts;

endpackage

FILE: rtl/etsw_ctrl.sv
// ----------------------------------------------------------------------------
// etsw_ctrl
// Sequencer: clearing sweep, load, write, per-cell read/divide/multiply/emit.
// ----------------------------------------------------------------------------
module etsw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_out_ready,
    input  etsw_pkg::t_sts  i_sts,
    output etsw_pkg::t_ctl  o_ctl
);
    import etsw_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DIV0  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       w_acc, w_take;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign w_take  = i_sts.out_full && i_out_ready;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.out_take = w_take;
        o_ctl.load     = w_acc;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_ctl.mem_write = 1'b1;
                if (i_sts.is_compute) n_state = S_READ;
                else n_state = S_IDLE;
            end
            S_READ: begin
                o_ctl.rd_cell = 1'b1;
                n_state = S_DIV0;
            end
            S_DIV0: begin
                o_ctl.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_full || w_take) begin
                    o_ctl.out_load  = 1'b1;
                    o_ctl.next_cell = 1'b1;
                    n_state = i_sts.win_end ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ctl.load) else $error("accept while busy");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> (!i_sts.out_full || i_out_ready))
        else $error("output overwritten");
    a_write_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> o_ctl.mem_write) else $error("load not followed by write");
`endif
endmodule

FILE: rtl/etsw_dp.sv
// ----------------------------------------------------------------------------
// etsw_dp
// Datapath: time, mark and weight stores, window counters, radix-2 divider,
// weighting multiplier and the output register.
// ----------------------------------------------------------------------------
module etsw_dp #(
    parameter int SENSOR_WIDTH  = etsw_pkg::SENSOR_WIDTH_DEF,
    parameter int SENSOR_HEIGHT = etsw_pkg::SENSOR_HEIGHT_DEF,
    parameter int RADIUS_X      = etsw_pkg::RADIUS_X_DEF,
    parameter int RADIUS_Y      = etsw_pkg::RADIUS_Y_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  etsw_pkg::t_ctl         i_ctl,
    output etsw_pkg::t_sts         o_sts,
    input  logic [1:0]             i_mode,
    input  logic [31:0]            i_timestamp,
    input  logic [6:0]             i_pix_x,
    input  logic [6:0]             i_pix_y,
    input  logic signed [15:0]     i_weight_in,
    input  logic [31:0]            i_decay_time,
    input  logic [5:0]             i_min_active,
    input  logic                   i_use_weights,
    output logic signed [16:0]     o_cell_value,
    output logic [2:0]             o_cell_dx,
    output logic [2:0]             o_cell_dy,
    output logic                   o_good,
    output logic                   o_last
);
    import etsw_pkg::*;

    localparam int XW     = $clog2(SENSOR_WIDTH);
    localparam int YW     = $clog2(SENSOR_HEIGHT);
    localparam int PIX    = SENSOR_WIDTH * SENSOR_HEIGHT;
    localparam int AW     = $clog2(PIX);
    localparam int WIN_W  = 2 * RADIUS_X + 1;
    localparam int WIN_H  = 2 * RADIUS_Y + 1;
    localparam int CW     = 12; // signed cell coordinates, sensors up to 1024 plus radius

    logic [31:0] time_mem [PIX];
    logic [15:0] wgt_mem  [PIX];
    logic        mark_mem [PIX];

    logic [1:0]  r_mode;
    logic [31:0] r_ts;
    logic [6:0]  r_px, r_py;
    logic [15:0] r_w;
    logic [2:0]  r_dx, r_dy;
    logic [5:0]  r_pos;
    logic [AW:0] r_clr;

    // Item pixel.
    logic       w_here;
    logic [AW-1:0] w_addr;
    assign w_here = ({4'b0, r_px} < 11'(SENSOR_WIDTH))
                    && ({4'b0, r_py} < 11'(SENSOR_HEIGHT));
    assign w_addr = AW'(r_py) * AW'(SENSOR_WIDTH) + AW'(r_px);

    // Current cell.
    logic signed [CW-1:0] w_cx, w_cy;
    logic                 w_con;
    logic [AW-1:0]        w_caddr;
    assign w_cx = $signed({2'b0, r_px}) + $signed({{(CW-3){1'b0}}, r_dx})
                  - CW'(RADIUS_X);
    assign w_cy = $signed({2'b0, r_py}) + $signed({{(CW-3){1'b0}}, r_dy})
                  - CW'(RADIUS_Y);
    assign w_con = (w_cx >= 0) && (w_cy >= 0) && (w_cx < CW'(SENSOR_WIDTH))
                   && (w_cy < CW'(SENSOR_HEIGHT));
    assign w_caddr = AW'(w_cy[YW-1:0]) * AW'(SENSOR_WIDTH) + AW'(w_cx[XW-1:0]);

    logic [31:0] r_rd_t;
    logic [15:0] r_rd_w;
    logic        r_rd_m, r_con;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_write && w_here) begin
            if (r_mode == MODE_WEIGHT) wgt_mem[w_addr] <= r_w;
            else if (r_mode != MODE_COMPUTE) time_mem[w_addr] <= r_ts;
        end
        if (i_ctl.rd_cell) begin
            r_rd_t <= time_mem[w_caddr];
            r_rd_w <= wgt_mem[w_caddr];
            r_con  <= w_con;
        end
    end

    // Mark store: cleared by a sweep after reset, then set by updates.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) mark_mem[r_clr[AW-1:0]] <= 1'b0;
        else if (i_ctl.mem_write && w_here
                 && (r_mode == MODE_UPDATE || r_mode == MODE_BOTH))
            mark_mem[w_addr] <= 1'b1;
        if (i_ctl.rd_cell) r_rd_m <= mark_mem[w_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_ctl.clr_step) r_clr <= r_clr + 1'b1;
    end
    assign o_sts.clr_done = (r_clr == (AW+1)'(PIX - 1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mode <= i_mode;
            r_ts   <= i_timestamp;
            r_px   <= i_pix_x;
            r_py   <= i_pix_y;
            r_w    <= i_weight_in;
        end
    end

    // Divider: floor((tau-age)*2^15/tau), restoring, one quotient bit a cycle.
    logic [32:0] r_rem;
    logic [15:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_zero;
    logic [32:0] w_age, w_trial;
    assign w_age   = (r_rd_t > r_ts) ? 33'd0 : {1'b0, r_ts - r_rd_t};
    assign w_trial = {r_rem[31:0], 1'b0} - {1'b0, i_decay_time};

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) begin
            r_zero <= !(r_con && r_rd_m) || (i_decay_time == 32'd0)
                      || (w_age >= {1'b0, i_decay_time});
            r_rem  <= {1'b0, i_decay_time} - w_age;
            r_quo  <= '0;
            r_cnt  <= '0;
        end else if (i_ctl.div_step) begin
            // quotient <= 2^15 fits in 16 bits; 16 iterations.
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 5'd0) begin
                // integer part: rem >= tau only when age is 0
                if (r_rem >= {1'b0, i_decay_time}) begin
                    r_quo <= 16'd1;
                    r_rem <= r_rem - {1'b0, i_decay_time};
                end
            end else if (!w_trial[32]) begin
                r_quo <= {r_quo[14:0], 1'b1};
                r_rem <= w_trial;
            end else begin
                r_quo <= {r_quo[14:0], 1'b0};
                r_rem <= {r_rem[31:0], 1'b0};
            end
        end
    end
    assign o_sts.div_done = (r_cnt == 5'd15);

    logic [15:0] w_val;
    assign w_val = r_zero ? 16'd0 : r_quo;

    // Weighting.
    logic signed [16:0] r_cv;
    logic               r_posf;
    logic signed [33:0] w_prod;
    logic signed [19:0] w_q;
    assign w_prod = $signed({1'b0, w_val}) * $signed(r_con ? r_rd_w : 16'd0);
    assign w_q    = w_prod[33:14];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_posf <= (w_val != 16'd0);
            if (!i_use_weights) r_cv <= $signed({1'b0, w_val});
            else if (w_q > 20'sd65535) r_cv <= 17'sd65535;
            else if (w_q < -20'sd65536) r_cv <= -17'sd65536;
            else r_cv <= w_q[16:0];
        end
    end

    logic w_wend;
    assign w_wend = (r_dx == 3'(WIN_W - 1)) && (r_dy == 3'(WIN_H - 1));
    logic [5:0] w_pos;
    assign w_pos = r_pos + {5'd0, r_posf};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dx <= '0; r_dy <= '0; r_pos <= '0;
        end else if (i_ctl.next_cell) begin
            r_pos <= w_pos;
            if (r_dx == 3'(WIN_W - 1)) begin
                r_dx <= '0;
                r_dy <= r_dy + 1'b1;
            end else r_dx <= r_dx + 1'b1;
        end
    end

    logic r_full;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else if (i_ctl.out_load) r_full <= 1'b1;
        else if (i_ctl.out_take) r_full <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_cell_value <= r_cv;
            o_cell_dx    <= r_dx;
            o_cell_dy    <= r_dy;
            o_last       <= w_wend;
            o_good       <= w_wend && (w_pos >= i_min_active);
        end
    end

    assign o_sts.win_end       = w_wend;
    assign o_sts.out_full      = r_full;
    assign o_sts.is_compute    = (r_mode == MODE_COMPUTE) || (r_mode == MODE_BOTH);

`ifndef SYNTHESIS
    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.mul |-> (w_val <= 16'd32768)) else $error("decay value too large");
    a_last_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !o_last) |-> !o_good) else $error("good off last cell");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.div_start |=> (r_cnt == 5'd0)) else $error("divider not reset");
`endif
endmodule

FILE: rtl/event_time_surface_window.sv
// ----------------------------------------------------------------------------
// event_time_surface_window
// Per-pixel last-event time surface with a linearly decaying window readout.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_valid/o_ready with mode, timestamp, pixel and
// weight. Mode 0 stores the timestamp, mode 3 stores the weight, mode 1
// reads the window around the pixel and mode 2 does both. A compute returns
// one transfer per window cell on o_valid/i_ready, row by row, with o_last
// on the final cell and o_good set there when >= min_active cells are nonzero.
// Sequence: a store-only item passes through the write state to idle. Each
// window cell is read, set up for the divider, run through 16 iterations of
// the radix-2 divider, multiplied and emitted; the shared divider dominates
// the time for a full 7x7 window.
// Reset: after reset the mark store is swept clear, one pixel per cycle,
// over all SENSOR_WIDTH*SENSOR_HEIGHT pixels (16384 by default); o_ready
// stays low during the sweep while configuration writes are still taken.
// Stall: the result register holds its transfer while i_ready is low, and
// the sequencer waits before emitting the next cell.
// ----------------------------------------------------------------------------
module event_time_surface_window #(
    parameter int SENSOR_WIDTH  = etsw_pkg::SENSOR_WIDTH_DEF,
    parameter int SENSOR_HEIGHT = etsw_pkg::SENSOR_HEIGHT_DEF,
    parameter int RADIUS_X      = etsw_pkg::RADIUS_X_DEF,
    parameter int RADIUS_Y      = etsw_pkg::RADIUS_Y_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    input  logic [31:0]         i_timestamp,
    input  logic [6:0]          i_pix_x,
    input  logic [6:0]          i_pix_y,
    input  logic signed [15:0]  i_weight_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [16:0]  o_cell_value,
    output logic [2:0]          o_cell_dx,
    output logic [2:0]          o_cell_dy,
    output logic                o_good,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import etsw_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic [31:0] r_decay;
    logic [5:0]  r_minact;
    logic        r_usew;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= DECAY_RESET;
            r_minact <= MINACT_RESET;
            r_usew   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DECAY:  r_decay  <= i_cfg_data;
                REG_MINACT: r_minact <= i_cfg_data[5:0];
                REG_USEW:   r_usew   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    etsw_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_out_ready (i_ready),
        .i_sts (w_sts), .o_ctl (w_ctl)
    );

    etsw_dp #(
        .SENSOR_WIDTH(SENSOR_WIDTH), .SENSOR_HEIGHT(SENSOR_HEIGHT),
        .RADIUS_X(RADIUS_X), .RADIUS_Y(RADIUS_Y)
    ) u_dp (
        .i_clk, .i_rst_n, .i_ctl (w_ctl), .o_sts (w_sts),
        .i_mode, .i_timestamp, .i_pix_x, .i_pix_y, .i_weight_in,
        .i_decay_time (r_decay), .i_min_active (r_minact), .i_use_weights (r_usew),
        .o_cell_value, .o_cell_dx, .o_cell_dy, .o_good, .o_last
    );

    assign o_valid = w_sts.out_full;

`ifndef SYNTHESIS
    a_cfg_minact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == REG_MINACT) |=> (r_minact == $past(i_cfg_data[5:0])))
        else $error("min_active not written");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cell_value)))
        else $error("result dropped while stalled");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |-> !w_ctl.out_load) else $error("emit during accept");
`endif
endmodule
